// ----- rtl/core/ufr_pkg.sv -----
// Package with the shared types and constants of the UART frame receiver.
`default_nettype none

package ufr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned TallyW = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 48;
  localparam int unsigned OutTuserW = 1;

  localparam logic [TallyW-1:0] TallyMax = {TallyW{1'b1}};

  localparam logic [ByteW-1:0] SyncFirstRst     = 8'h41;
  localparam logic [ByteW-1:0] SyncSecondRst    = 8'h78;
  localparam logic [ByteW-1:0] DeviceAddressRst = 8'hFF;
  localparam logic [ByteW-1:0] FooterByteRst    = 8'h6D;
  localparam logic [ByteW-1:0] DataCommandRst   = 8'h06;
  localparam logic [ByteW-1:0] DataMessageRst   = 8'h81;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSyncFirst     = 3'd0,
    CfgSyncSecond    = 3'd1,
    CfgDeviceAddress = 3'd2,
    CfgFooterByte    = 3'd3,
    CfgDataCommand   = 3'd4,
    CfgDataMessage   = 3'd5
  } cfg_index_e;

  typedef enum logic [8:0] {
    PhSync1   = 9'b000000001,
    PhSync2   = 9'b000000010,
    PhAddr    = 9'b000000100,
    PhCmd     = 9'b000001000,
    PhMsg     = 9'b000010000,
    PhLen     = 9'b000100000,
    PhPayload = 9'b001000000,
    PhCheck   = 9'b010000000,
    PhFooter  = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic              frame_done;
    logic              frame_is_data;
    logic [NibW-1:0]   command_nibble;
    logic [NibW-1:0]   error_nibble;
    logic [ByteW-1:0]  message_id;
    logic [ByteW-1:0]  length_field;
    logic [ByteW-1:0]  check_byte;
    logic [TallyW-1:0] frame_bytes;
    logic              sync_lost;
    logic              payload_strobe;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/uart_frame_receiver.sv -----
// Top level of the UART frame receiver: byte-wise frame parser with a result register.
//
// Channel  | Direction | Payload
// s_axis   | in        | tdata[7:0] rx_byte
// m_axis   | out       | tdata: frame fields, tlast frame_done, tuser frame_is_data
// cfg      | in        | cfg_index_i register index, cfg_data_i register value
//
// Each byte is parsed in the cycle it is accepted, and its result appears in the
// output register on the next cycle, so one byte per cycle is sustained while
// m_axis_tready is high. The input is stalled only while a result waits in the
// output register and m_axis_tready is low. Configuration writes are always accepted.
// Reset loads the default register values and returns the parser to the header hunt.
`default_nettype none

module uart_frame_receiver (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // tdata: rx_byte[7:0]
  input  wire logic [ufr_pkg::InTdataW-1:0]      s_axis_tdata,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: command_nibble[3:0], error_nibble[7:4], message_id[15:8],
  // length_field[23:16], check_byte[31:24], frame_bytes[40:32],
  // sync_lost[41], payload_strobe[42], zero[47:43]
  output      logic [ufr_pkg::OutTdataW-1:0]     m_axis_tdata,
  // tlast: frame_done
  output      logic                              m_axis_tlast,
  // tuser: frame_is_data[0]
  output      logic [ufr_pkg::OutTuserW-1:0]     m_axis_tuser,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [ufr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [ufr_pkg::ByteW-1:0]         cfg_data_i
);

  logic [ufr_pkg::ByteW-1:0] sync_first_q, sync_second_q, device_address_q;
  logic [ufr_pkg::ByteW-1:0] footer_byte_q, data_command_q, data_message_q;

  ufr_pkg::phase_e phase_q, phase_d;
  logic [ufr_pkg::ByteW-1:0]  cmd_q, cmd_d, msg_q, msg_d, len_q, len_d;
  logic [ufr_pkg::ByteW-1:0]  seen_q, seen_d, chk_q, chk_d;
  logic [ufr_pkg::TallyW-1:0] tally_q, tally_d;

  ufr_pkg::result_t res_d, res_q;
  logic             out_valid_q;
  logic             in_fire;
  logic [ufr_pkg::ByteW-1:0]  rx;
  logic [ufr_pkg::ByteW-1:0]  seen_inc;
  logic [ufr_pkg::TallyW-1:0] tally_inc;
  logic done, is_data, lost, strobe;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign rx            = s_axis_tdata[ufr_pkg::ByteW-1:0];
  assign seen_inc      = seen_q + 8'd1;
  assign tally_inc     = (tally_q != ufr_pkg::TallyMax) ? tally_q + 9'd1 : tally_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q     <= ufr_pkg::SyncFirstRst;
      sync_second_q    <= ufr_pkg::SyncSecondRst;
      device_address_q <= ufr_pkg::DeviceAddressRst;
      footer_byte_q    <= ufr_pkg::FooterByteRst;
      data_command_q   <= ufr_pkg::DataCommandRst;
      data_message_q   <= ufr_pkg::DataMessageRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ufr_pkg::cfg_index_e'(cfg_index_i))
        ufr_pkg::CfgSyncFirst:     sync_first_q     <= cfg_data_i;
        ufr_pkg::CfgSyncSecond:    sync_second_q    <= cfg_data_i;
        ufr_pkg::CfgDeviceAddress: device_address_q <= cfg_data_i;
        ufr_pkg::CfgFooterByte:    footer_byte_q    <= cfg_data_i;
        ufr_pkg::CfgDataCommand:   data_command_q   <= cfg_data_i;
        ufr_pkg::CfgDataMessage:   data_message_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    msg_d   = msg_q;
    len_d   = len_q;
    seen_d  = seen_q;
    chk_d   = chk_q;
    tally_d = tally_inc;
    done    = 1'b0;
    is_data = 1'b0;
    lost    = 1'b0;
    strobe  = 1'b0;

    case (phase_q)
      ufr_pkg::PhSync2: begin
        if (rx == sync_second_q) phase_d = ufr_pkg::PhAddr;
        else lost = 1'b1;
      end
      ufr_pkg::PhAddr: begin
        if (rx == device_address_q) phase_d = ufr_pkg::PhCmd;
        else lost = 1'b1;
      end
      ufr_pkg::PhCmd: begin
        cmd_d   = rx;
        phase_d = ufr_pkg::PhMsg;
      end
      ufr_pkg::PhMsg: begin
        msg_d   = rx;
        phase_d = ufr_pkg::PhLen;
      end
      ufr_pkg::PhLen: begin
        len_d   = rx;
        phase_d = (rx != 8'd0) ? ufr_pkg::PhPayload : ufr_pkg::PhCheck;
      end
      ufr_pkg::PhPayload: begin
        strobe = 1'b1;
        seen_d = seen_inc;
        if (seen_inc == len_q) begin
          phase_d = ufr_pkg::PhCheck;
        end else if (seen_inc > len_q) begin
          seen_d  = 8'd0;
          phase_d = ufr_pkg::PhSync1;
        end
      end
      ufr_pkg::PhCheck: begin
        chk_d   = rx;
        phase_d = ufr_pkg::PhFooter;
      end
      ufr_pkg::PhFooter: begin
        if (rx == footer_byte_q) begin
          done    = 1'b1;
          is_data = (cmd_q == data_command_q) && (msg_q == data_message_q);
        end
      end
      default: begin
        if (rx == sync_first_q) phase_d = ufr_pkg::PhSync2;
        else lost = 1'b1;
      end
    endcase

    if (lost) begin
      tally_d = '0;
      phase_d = ufr_pkg::PhSync1;
    end

    res_d.frame_done     = done;
    res_d.frame_is_data  = is_data;
    res_d.command_nibble = cmd_d[3:0];
    res_d.error_nibble   = cmd_d[7:4];
    res_d.message_id     = msg_d;
    res_d.length_field   = len_d;
    res_d.check_byte     = chk_d;
    res_d.frame_bytes    = tally_d;
    res_d.sync_lost      = lost;
    res_d.payload_strobe = strobe;

    if (done) begin
      cmd_d   = '0;
      msg_d   = '0;
      len_d   = '0;
      seen_d  = '0;
      chk_d   = '0;
      tally_d = '0;
      phase_d = ufr_pkg::PhSync1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ufr_pkg::PhSync1;
      cmd_q       <= '0;
      msg_q       <= '0;
      len_q       <= '0;
      seen_q      <= '0;
      chk_q       <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        msg_q   <= msg_d;
        len_q   <= len_d;
        seen_q  <= seen_d;
        chk_q   <= chk_d;
        tally_q <= tally_d;
      end
      if (in_fire) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.frame_done;
  assign m_axis_tuser  = res_q.frame_is_data;
  assign m_axis_tdata  = {5'd0, res_q.payload_strobe, res_q.sync_lost, res_q.frame_bytes,
                          res_q.check_byte, res_q.length_field, res_q.message_id,
                          res_q.error_nibble, res_q.command_nibble};

  // A pending result that is not taken must hold off the next byte.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while a result is stalled");

  // A closed frame never coincides with a lost header or a payload byte.
  a_done_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tdata[41] && !m_axis_tdata[42]))
    else $error("frame close together with sync loss or payload byte");

  // Only a closed frame can be flagged as a data frame.
  a_data_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("data frame flag without frame close");

  // The shortest frame spans eight bytes from the first header byte.
  a_min_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[40:32] >= 9'd8))
    else $error("frame closed with too few bytes counted");

  // A lost header always restarts the byte count.
  a_lost_clears_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[41]) |-> (m_axis_tdata[40:32] == 9'd0))
    else $error("sync loss with nonzero byte count");

endmodule

`default_nettype wire
